// File: sv/ray_box_slab_intersect_assert.svh
// Assertion macros used by the slab-test top module.
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RBSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rbsi assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RBSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rbsi assertion failed");

`endif

// File: sv/rbsi_pkg.sv
package rbsi_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned THRESH_W      = 17;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd66;
  localparam int unsigned APB_ADDR_W    = 3;
  // Register index as decoded from paddr[2].
  localparam logic REG_THRESH = 1'b0;
  // Divider stages: magnitude stage, range stage, 32 quotient-bit stages, output.
  localparam int unsigned DIV_LAT = 35;
  localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic [30:0]        half_z;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        entry_t;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
  } result_t;

  // What one axis lane reports to the merge stage.
  typedef struct packed {
    logic               par;
    logic               pmiss;
    logic signed [31:0] t_lo;
    logic signed [31:0] t_hi;
  } slab_t;

endpackage

// File: sv/ray_box_slab_intersect.sv
// Ray versus axis-aligned box test by the slab method, signed fixed point with
// FRAC_BITS fraction bits. Pulse start with a ray (origin, direction) and a box
// (centre, half extents) on item_i; busy never rises, so a new word can be
// issued on every clock. Each word yields exactly one result word on result_o,
// flagged by done_o for a single cycle, in issue order. The receiver cannot
// stall: capture the result in the cycle done_o is high or lose it. The latency
// is set by the slab distance dividers, which resolve one quotient bit per
// pipeline stage (32 stages plus three for magnitude, range check and sign).
// On a miss, entry_t and hit_x/y/z read zero. Distances and the hit point
// saturate to the 32-bit signed range, so an entry_t of the maximum value may
// stand for a farther entry. The parallel threshold register sits at APB
// address 0 and resets to 66 (about 0.001).
module ray_box_slab_intersect #(
  parameter int unsigned FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  rbsi_pkg::item_t                 item_i,
  output logic                            done_o,
  output rbsi_pkg::result_t               result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbsi_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import rbsi_pkg::*;

  `include "ray_box_slab_intersect_assert.svh"

  // Entry stage, divider, sort, merge, multiply.
  localparam int unsigned VLD_N   = DIV_LAT + 4;
  localparam int unsigned RES_LAT = VLD_N + 1;

  logic [THRESH_W-1:0] thresh_d, thresh_q;
  logic                cfg_wr;
  logic                accept;
  logic [VLD_N-1:0]    vld_q;
  logic                done_q;
  result_t             result_q;

  slab_t               slab   [0:2];
  logic signed [31:0]  org_d  [0:2];
  logic signed [31:0]  dir_d  [0:2];
  logic signed [31:0]  pos    [0:2];
  logic signed [31:0]  org_in [0:2];
  logic signed [31:0]  dir_in [0:2];
  logic signed [31:0]  cen_in [0:2];
  logic [30:0]         half_in[0:2];

  logic                hit_m;
  logic [30:0]         tmin_m;
  logic                hit_q;
  logic [30:0]         tmin_q;

  // The pipeline never stalls, so the command side is always open.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration port: zero-wait APB, one register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_THRESH) ? 32'(thresh_q) : 32'd0;

  always_comb begin
    thresh_d = thresh_q;
    if (cfg_wr && (paddr[2] == REG_THRESH)) begin
      thresh_d = pwdata[THRESH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else begin
      thresh_q <= thresh_d;
    end
  end

  // Split the word into per-axis lane inputs.
  assign org_in  = '{item_i.origin_x, item_i.origin_y, item_i.origin_z};
  assign dir_in  = '{item_i.dir_x, item_i.dir_y, item_i.dir_z};
  assign cen_in  = '{item_i.centre_x, item_i.centre_y, item_i.centre_z};
  assign half_in = '{item_i.half_x, item_i.half_y, item_i.half_z};

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i    (clk_i),
      .thresh_i (thresh_q),
      .org_i    (org_in[a]),
      .dir_i    (dir_in[a]),
      .cen_i    (cen_in[a]),
      .half_i   (half_in[a]),
      .slab_o   (slab[a]),
      .org_o    (org_d[a]),
      .dir_o    (dir_d[a])
    );

    rbsi_point #(.FRAC_BITS(FRAC_BITS)) u_point (
      .clk_i (clk_i),
      .org_i (org_d[a]),
      .dir_i (dir_d[a]),
      .t_i   (tmin_m),
      .pos_o (pos[a])
    );
  end

  // Combine the three lanes into one interval.
  rbsi_merge u_merge (
    .clk_i  (clk_i),
    .slab_i (slab),
    .hit_o  (hit_m),
    .tmin_o (tmin_m)
  );

  // Hold hit and entry t for the multiply stage.
  always_ff @(posedge clk_i) begin
    hit_q  <= hit_m;
    tmin_q <= tmin_m;
  end

  // Output word: zero everything but the flag on a miss.
  always_ff @(posedge clk_i) begin
    result_q.hit     <= hit_q;
    result_q.entry_t <= hit_q ? tmin_q : 31'd0;
    result_q.hit_x   <= hit_q ? pos[0] : 32'sd0;
    result_q.hit_y   <= hit_q ? pos[1] : 32'sd0;
    result_q.hit_z   <= hit_q ? pos[2] : 32'sd0;
  end

  // Valid tokens track each word down the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[VLD_N-2:0], accept};
      done_q <= vld_q[VLD_N-1];
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `RBSI_ASSERT_NOW(a_done_follows_start, clk_i, rst_ni, done_o, $past(accept, RES_LAT))
  `RBSI_ASSERT_NOW(a_start_gives_done, clk_i, rst_ni, accept, ##RES_LAT done_o)
  `RBSI_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, done_o && !result_o.hit, (result_o.entry_t == 31'd0) && (result_o.hit_x == 32'sd0) && (result_o.hit_y == 32'sd0) && (result_o.hit_z == 32'sd0))
  `RBSI_ASSERT_NEXT(a_thresh_only_on_write, clk_i, rst_ni, !(cfg_wr && (paddr[2] == REG_THRESH)), $stable(thresh_q))

endmodule

// File: sv/rbsi_div.sv
module rbsi_div #(
  parameter int unsigned FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic signed [33:0] num_i,
  input  logic signed [31:0] den_i,
  output logic signed [31:0] quo_o
);
  import rbsi_pkg::*;

  localparam int unsigned QB = 32;

  logic [32:0] nmag_q;
  logic [31:0] dmag_q;
  logic        neg_q;

  logic [31:0] r_q  [0:QB];
  logic [31:0] nl_q [0:QB];
  logic [31:0] d_q  [0:QB];
  logic [31:0] q_q  [0:QB];
  logic        ng_q [0:QB];
  logic        ov_q [0:QB];

  logic [63:0] nfull;
  logic        big;
  logic signed [31:0] quo_d, quo_q;

  assign nfull = 64'(nmag_q) << FRAC_BITS;

  // Take magnitudes and the quotient sign.
  always_ff @(posedge clk_i) begin
    nmag_q <= num_i[33] ? 33'(-num_i) : 33'(num_i);
    dmag_q <= den_i[31] ? 32'(-den_i) : 32'(den_i);
    neg_q  <= num_i[33] ^ den_i[31];
  end

  // Range check, then one quotient bit per stage.
  always_ff @(posedge clk_i) begin
    r_q[0]  <= nfull[63:32];
    nl_q[0] <= nfull[31:0];
    d_q[0]  <= dmag_q;
    q_q[0]  <= '0;
    ng_q[0] <= neg_q;
    ov_q[0] <= nfull[63:32] >= dmag_q;
    for (int k = 0; k < QB; k++) begin
      logic [32:0] rs;
      logic        ge;
      rs = {r_q[k], nl_q[k][31]};
      ge = rs >= {1'b0, d_q[k]};
      r_q[k+1]  <= ge ? 32'(rs - {1'b0, d_q[k]}) : rs[31:0];
      nl_q[k+1] <= {nl_q[k][30:0], 1'b0};
      d_q[k+1]  <= d_q[k];
      q_q[k+1]  <= {q_q[k][30:0], ge};
      ng_q[k+1] <= ng_q[k];
      ov_q[k+1] <= ov_q[k];
    end
  end

  assign big = ov_q[QB] || q_q[QB][31];

  always_comb begin
    if (big) begin
      quo_d = ng_q[QB] ? T_MIN : T_MAX;
    end else if (ng_q[QB]) begin
      quo_d = -$signed(q_q[QB]);
    end else begin
      quo_d = $signed(q_q[QB]);
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

// File: sv/rbsi_lane.sv
module rbsi_lane #(
  parameter int unsigned FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic [rbsi_pkg::THRESH_W-1:0]   thresh_i,
  input  logic signed [31:0]              org_i,
  input  logic signed [31:0]              dir_i,
  input  logic signed [31:0]              cen_i,
  input  logic [30:0]                     half_i,
  output rbsi_pkg::slab_t                 slab_o,
  output logic signed [31:0]              org_o,
  output logic signed [31:0]              dir_o
);
  import rbsi_pkg::*;

  localparam int unsigned DLY = DIV_LAT + 2;

  typedef struct packed {
    logic signed [31:0] org;
    logic signed [31:0] dir;
    logic               par;
    logic               pmiss;
  } side_t;

  logic signed [33:0] na_q, nb_q;
  logic signed [32:0] diff;
  logic [32:0]        adiff_q;
  logic [31:0]        adir;
  logic [30:0]        half_q;
  logic               par_q;
  logic signed [31:0] org_q, dir_q;
  logic signed [31:0] ta, tb;
  side_t              side_q [0:DLY-1];
  slab_t              slab_q;

  assign diff = 33'(org_i) - 33'(cen_i);
  assign adir = dir_i[31] ? 32'(-dir_i) : 32'(dir_i);

  // Entry stage: slab numerators, origin offset, parallel flag.
  always_ff @(posedge clk_i) begin
    na_q    <= 34'(cen_i) - 34'({1'b0, half_i}) - 34'(org_i);
    nb_q    <= 34'(cen_i) + 34'({1'b0, half_i}) - 34'(org_i);
    adiff_q <= diff[32] ? 33'(-diff) : 33'(diff);
    half_q  <= half_i;
    par_q   <= (dir_i == 32'sd0) || (adir < 32'(thresh_i));
    org_q   <= org_i;
    dir_q   <= dir_i;
  end

  rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
    .clk_i (clk_i),
    .num_i (na_q),
    .den_i (dir_q),
    .quo_o (ta)
  );

  rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
    .clk_i (clk_i),
    .num_i (nb_q),
    .den_i (dir_q),
    .quo_o (tb)
  );

  // Carry side data alongside the dividers.
  always_ff @(posedge clk_i) begin
    side_q[0] <= '{org: org_q, dir: dir_q, par: par_q,
                   pmiss: adiff_q > {2'b00, half_q}};
    for (int k = 1; k < DLY; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // Order the two slab distances.
  always_ff @(posedge clk_i) begin
    slab_q.par   <= side_q[DIV_LAT-1].par;
    slab_q.pmiss <= side_q[DIV_LAT-1].pmiss;
    slab_q.t_lo  <= (ta > tb) ? tb : ta;
    slab_q.t_hi  <= (ta > tb) ? ta : tb;
  end

  assign slab_o = slab_q;
  assign org_o  = side_q[DLY-1].org;
  assign dir_o  = side_q[DLY-1].dir;

endmodule

// File: sv/rbsi_merge.sv
module rbsi_merge (
  input  logic            clk_i,
  input  rbsi_pkg::slab_t slab_i [0:2],
  output logic            hit_o,
  output logic [30:0]     tmin_o
);
  import rbsi_pkg::*;

  logic signed [31:0] tmin, tmax;
  logic               miss;
  logic               hit_q;
  logic [30:0]        tmin_q;

  // Narrow [0, max] by every non-parallel axis.
  always_comb begin
    tmin = 32'sd0;
    tmax = T_MAX;
    miss = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (slab_i[i].par) begin
        if (slab_i[i].pmiss) begin
          miss = 1'b1;
        end
      end else begin
        if (slab_i[i].t_lo > tmin) begin
          tmin = slab_i[i].t_lo;
        end
        if (slab_i[i].t_hi < tmax) begin
          tmax = slab_i[i].t_hi;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= !miss && !(tmin > tmax);
    tmin_q <= tmin[30:0];
  end

  assign hit_o  = hit_q;
  assign tmin_o = tmin_q;

endmodule

// File: sv/rbsi_point.sv
module rbsi_point #(
  parameter int unsigned FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic signed [31:0] org_i,
  input  logic signed [31:0] dir_i,
  input  logic [30:0]        t_i,
  output logic signed [31:0] pos_o
);
  import rbsi_pkg::*;

  logic signed [63:0] prod_q;
  logic signed [31:0] org_q;
  logic signed [63:0] sum;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(dir_i) * 64'($signed({1'b0, t_i}));
    org_q  <= org_i;
  end

  // Arithmetic shift floors toward minus infinity.
  assign sum = 64'(org_q) + (prod_q >>> FRAC_BITS);

  always_comb begin
    if (sum > 64'(T_MAX)) begin
      pos_o = T_MAX;
    end else if (sum < 64'(T_MIN)) begin
      pos_o = T_MIN;
    end else begin
      pos_o = sum[31:0];
    end
  end

endmodule

// File: verif/rbsi_checker.sv
`timescale 1ns / 100ps

module rbsi_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  rbsi_pkg::item_t   item_i,
  input  logic              done_o,
  input  rbsi_pkg::result_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [rbsi_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending_count
);
  import rbsi_pkg::*;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  logic [THRESH_W-1:0] thresh_q;
  result_t             expected_words[$];
  int                  mismatch_count;

  function automatic longint clip32(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint floor_frac(longint v);
    return v >>> FRAC_BITS;
  endfunction

  // Slab test: narrow [0, max] per axis, parallel axes test containment only.
  function automatic result_t slab_result(item_t it, logic [THRESH_W-1:0] th);
    longint org[3], dv[3], cen[3], hf[3];
    longint tmin, tmax, t1, t2, tmp, ad;
    logic   hit;
    result_t r;
    org = '{longint'(it.origin_x), longint'(it.origin_y), longint'(it.origin_z)};
    dv  = '{longint'(it.dir_x), longint'(it.dir_y), longint'(it.dir_z)};
    cen = '{longint'(it.centre_x), longint'(it.centre_y), longint'(it.centre_z)};
    hf  = '{longint'({1'b0, it.half_x}), longint'({1'b0, it.half_y}),
            longint'({1'b0, it.half_z})};
    tmin = 0;
    tmax = SAT_HI;
    hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (hit) begin
        ad = abs64(dv[i]);
        if (dv[i] == 0 || ad < longint'({1'b0, th})) begin
          if (abs64(org[i] - cen[i]) > hf[i]) hit = 1'b0;
        end else begin
          t1 = clip32(((cen[i] - hf[i] - org[i]) <<< FRAC_BITS) / dv[i]);
          t2 = clip32(((cen[i] + hf[i] - org[i]) <<< FRAC_BITS) / dv[i]);
          if (t1 > t2) begin
            tmp = t1; t1 = t2; t2 = tmp;
          end
          if (t1 > tmin) tmin = t1;
          if (t2 < tmax) tmax = t2;
          if (tmin > tmax) hit = 1'b0;
        end
      end
    end
    r = '0;
    if (hit) begin
      r.hit     = 1'b1;
      r.entry_t = tmin[30:0];
      r.hit_x   = 32'(clip32(org[0] + floor_frac(dv[0] * tmin)));
      r.hit_y   = 32'(clip32(org[1] + floor_frac(dv[1] * tmin)));
      r.hit_z   = 32'(clip32(org[2] + floor_frac(dv[2] * tmin)));
    end
    return r;
  endfunction

  assign fail_count    = mismatch_count;
  assign pending_count = expected_words.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_w;
    if (!rst_ni) begin
      thresh_q       <= THRESH_RESET;
      mismatch_count <= 0;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_THRESH)
        thresh_q <= pwdata[THRESH_W-1:0];
      // Check before predicting: a new word cannot finish in the cycle it enters.
      if (done_o) begin
        if (expected_words.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result word %h", result_o);
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (result_o !== exp_w) begin
            if (mismatch_count < 10)
              $display("mismatch: hit %b/%b t %h/%h x %h/%h y %h/%h z %h/%h",
                exp_w.hit, result_o.hit, exp_w.entry_t, result_o.entry_t,
                exp_w.hit_x, result_o.hit_x, exp_w.hit_y, result_o.hit_y,
                exp_w.hit_z, result_o.hit_z);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (start && !busy) expected_words.push_back(slab_result(item_i, thresh_q));
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import rbsi_pkg::*;

  localparam int DRAIN_CYCLES = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  item_t       item_i = '0;
  logic        done_o;
  result_t     result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending_count;
  bit          no_gaps;

  always #6 clk_i = ~clk_i;

  ray_box_slab_intersect u_dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rbsi_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending_count
  );

  // Write the threshold register: setup cycle, then access cycle.
  task automatic write_thresh(logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_THRESH, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drive one word and hold it until the block takes it; a drain, or a next call
  // that inserts a gap, drops start at the following falling edge.
  task automatic send_word(item_t w);
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < 19) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (busy);
  endtask

  // Wait out every outstanding word, then the pipeline tail.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int unsigned mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 << 16)) - (1 << 16));
      default: return 32'($signed($urandom_range(40 << 16)) - (20 << 16));
    endcase
  endfunction

  // Mostly rays aimed near a box of modest size, so hits and all exits occur.
  function automatic item_t rand_word();
    item_t w;
    int unsigned mode;
    mode = $urandom_range(9);
    w.origin_x = rand_coord(mode); w.origin_y = rand_coord(mode);
    w.origin_z = rand_coord(mode);
    w.centre_x = rand_coord(mode); w.centre_y = rand_coord(mode);
    w.centre_z = rand_coord(mode);
    w.dir_x = rand_coord(mode > 6 ? 0 : 1);
    w.dir_y = rand_coord(mode > 6 ? 0 : 1);
    w.dir_z = rand_coord(mode > 6 ? 0 : 1);
    // Occasionally make an axis nearly parallel or exactly zero.
    if ($urandom_range(7) == 0) w.dir_x = 32'($signed($urandom_range(200)) - 100);
    if ($urandom_range(7) == 0) w.dir_y = '0;
    if (mode == 0) begin
      w.half_x = 31'($urandom()); w.half_y = 31'($urandom()); w.half_z = 31'($urandom());
    end else begin
      w.half_x = 31'($urandom_range(8 << 16)); w.half_y = 31'($urandom_range(8 << 16));
      w.half_z = 31'($urandom_range(8 << 16));
    end
    return w;
  endfunction

  task automatic directed_words();
    item_t w;
    // Unit box at origin, ray from -x toward +x: hit.
    w = '0;
    w.origin_x = -32'sd5 <<< 16; w.dir_x = 32'sd1 <<< 16;
    w.half_x = 31'd1 << 16; w.half_y = 31'd1 << 16; w.half_z = 31'd1 << 16;
    send_word(w);
    // Same, pointing away: miss.
    w.dir_x = -32'sd1 <<< 16; send_word(w);
    // Origin inside the box: entry at zero.
    w.origin_x = '0; send_word(w);
    // All axes parallel, outside one slab: miss.
    w.dir_x = '0; w.origin_y = 32'sd3 <<< 16; send_word(w);
    // Direction just below and at the threshold.
    w = '0; w.half_x = 31'd65536; w.half_y = 31'd65536; w.half_z = 31'd65536;
    w.origin_x = -32'sd4 <<< 16; w.dir_x = 32'sd65; send_word(w);
    w.dir_x = 32'sd66; send_word(w);
    // Extremes: all ones, all zeros, most negative.
    send_word('1);
    send_word('0);
    w.origin_x = 32'sh8000_0000; w.origin_y = 32'sh7FFF_FFFF; w.origin_z = 32'sh8000_0000;
    w.dir_x = 32'sh8000_0000; w.dir_y = 32'sh7FFF_FFFF; w.dir_z = 32'sh0000_0001;
    w.centre_x = 32'sh7FFF_FFFF; w.centre_y = 32'sh8000_0000; w.centre_z = 32'sh7FFF_FFFF;
    w.half_x = '1; w.half_y = '1; w.half_z = '1;
    send_word(w);
    // Saturating distance and hit point: far box, tiny direction.
    w = '0; w.origin_x = 32'sh8000_0000; w.centre_x = 32'sh7FFF_0000;
    w.dir_x = 32'sd70; w.half_x = '1; w.half_y = '1; w.half_z = '1;
    w.dir_y = 32'sh7FFF_FFFF; send_word(w);
    // Empty interval from two crossing slabs.
    w = '0; w.origin_x = -32'sd5 <<< 16; w.origin_y = 32'sd5 <<< 16;
    w.dir_x = 32'sd1 <<< 16; w.dir_y = 32'sd1 <<< 16;
    w.half_x = 31'd1 << 16; w.half_y = 31'd1 << 16; w.half_z = 31'd1 << 16;
    send_word(w);
    // Negative direction with fractional floor in the hit point.
    w = '0; w.origin_x = 32'sd10 <<< 16; w.dir_x = -32'sd3 <<< 15; w.dir_y = -32'sd7;
    w.half_x = 31'd1 << 16; w.half_y = 31'd9 << 16; w.half_z = 31'd9 << 16;
    send_word(w);
  endtask

  initial begin
    int threshes[4];
    threshes = '{0, 65536, 1000, 66};
    no_gaps = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    directed_words();
    drain();
    foreach (threshes[p]) begin
      write_thresh(threshes[p]);
      directed_words();
      // One phase runs back to back with no gaps.
      no_gaps = (p == 1);
      for (int n = 0; n < 130; n++) begin
        send_word(rand_word());
        // Hold off until the pipeline empties, once.
        if (p == 2 && n == 60) drain();
      end
      no_gaps = 1'b0;
      drain();
    end
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb failed");
    $finish;
  end

endmodule

// File: ray_box_slab_intersect.f
+incdir+sv
sv/rbsi_pkg.sv
sv/rbsi_div.sv
sv/rbsi_lane.sv
sv/rbsi_merge.sv
sv/rbsi_point.sv
sv/ray_box_slab_intersect.sv
verif/rbsi_checker.sv
verif/tb.sv
